// ===== hdl/xled_pkg.sv =====
// Shared types, codes, entity tables and step functions of the XML line entity decode parser.
package xled_pkg;

  // Byte codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Parser states
  localparam logic [2:0] ST_PRE   = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_ATTR  = 3'd2;
  localparam logic [2:0] ST_AVAL  = 3'd3;
  localparam logic [2:0] ST_TEXT  = 3'd4;
  localparam logic [2:0] ST_END   = 3'd5;

  // Pending one-byte lookahead
  localparam logic [1:0] LA_NONE  = 2'd0;
  localparam logic [1:0] LA_OPEN  = 2'd1;
  localparam logic [1:0] LA_EQUAL = 2'd2;
  localparam logic [1:0] LA_QUOTE = 2'd3;

  // Result labels
  localparam logic [2:0] PART_TAG  = 3'd0;
  localparam logic [2:0] PART_ANAM = 3'd1;
  localparam logic [2:0] PART_AVAL = 3'd2;
  localparam logic [2:0] PART_TEXT = 3'd3;
  localparam logic [2:0] PART_ETAG = 3'd4;

  // Line status
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_ABORT      = 2'd1;
  localparam logic [1:0] STAT_BAD_ENTITY = 2'd2;

  // Predefined entities: lt gt amp apos quot
  localparam int ENT_NUM    = 5;
  localparam int ENT_MAXLEN = 5;
  localparam int ENT_POS_W  = $clog2(ENT_MAXLEN);
  localparam int ENT_CNT_W  = $clog2(ENT_MAXLEN + 2);
  localparam logic [ENT_CNT_W-1:0] ENT_CNT_MAX   = ENT_CNT_W'(ENT_MAXLEN);
  // Count at which two or more bytes are held after the ampersand
  localparam logic [ENT_CNT_W-1:0] ENT_CNT_SHORT = ENT_CNT_W'(3);

  localparam logic [7:0] ENT_TEXT [ENT_NUM][ENT_MAXLEN] = '{
    '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
    '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
    '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B}
  };
  localparam logic [ENT_POS_W-1:0] ENT_LEN [ENT_NUM] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5};
  localparam logic [7:0] ENT_CHAR [ENT_NUM] = '{8'h3C, 8'h3E, 8'h26, 8'h27, 8'h22};

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Result slots per input item
  localparam int SLOTS  = 4;
  localparam int SLOT_W = $clog2(SLOTS);

  typedef struct packed {
    logic [7:0] character;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character_res;
    logic [2:0] part;
    logic       end_record;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] pstate;
    logic [1:0] la;
    logic       abort;
  } parse_st_t;

  typedef struct packed {
    parse_st_t  st;
    logic       lt_vld;    // held '<' goes out as text
    logic       lbl_vld;   // current byte goes out labelled
    logic [2:0] lbl_part;
  } parse_out_t;

  typedef struct packed {
    logic [ENT_NUM-1:0] alive;
    logic               full;
    logic [7:0]         ch;
  } ent_out_t;

  typedef struct packed {
    logic [SLOTS-1:0]      vld;
    out_item_t [SLOTS-1:0] item;
  } bundle_t;

  // One parser step on a decoded byte
  function automatic parse_out_t parse_step(parse_st_t s_in, logic [7:0] c);
    parse_out_t r;
    logic [2:0] ps;
    logic       skip;
    r          = '0;
    r.st       = s_in;
    ps         = s_in.pstate;
    skip       = 1'b0;
    r.lbl_part = PART_TAG;
    if (!s_in.abort) begin
      if (s_in.la == LA_EQUAL || s_in.la == LA_QUOTE) begin
        r.st.la = LA_NONE;
        if (c == ((s_in.la == LA_EQUAL) ? CH_DQUOTE : CH_GT)) begin
          r.st.pstate = (s_in.la == LA_EQUAL) ? ST_AVAL : ST_TEXT;
        end else begin
          r.st.abort = 1'b1;
        end
      end else begin
        if (s_in.la == LA_OPEN) begin
          r.st.la = LA_NONE;
          if (c == CH_SLASH) begin
            r.st.pstate = ST_END;
            skip        = 1'b1;
          end else if (ps == ST_TEXT) begin
            r.lt_vld = 1'b1;
          end else begin
            ps = ST_START;
          end
        end
        if (!skip) begin
          r.st.pstate = ps;
          case (ps)
            ST_START: begin
              if (c == CH_SPACE) r.st.pstate = ST_ATTR;
              else if (c == CH_GT) r.st.pstate = ST_TEXT;
              else begin
                r.lbl_vld  = (c != CH_NUL);
                r.lbl_part = PART_TAG;
              end
            end
            ST_ATTR: begin
              if (c == CH_EQUAL) r.st.la = LA_EQUAL;
              else if (c == CH_GT) r.st.pstate = ST_TEXT;
              else begin
                r.lbl_vld  = (c != CH_NUL);
                r.lbl_part = PART_ANAM;
              end
            end
            ST_AVAL: begin
              if (c == CH_DQUOTE) r.st.la = LA_QUOTE;
              else begin
                r.lbl_vld  = (c != CH_NUL);
                r.lbl_part = PART_AVAL;
              end
            end
            ST_TEXT: begin
              if (c == CH_LT) r.st.la = LA_OPEN;
              else begin
                r.lbl_vld  = (c != CH_NUL);
                r.lbl_part = PART_TEXT;
              end
            end
            ST_END: begin
              if (!(c inside {CH_GT, CH_CR, CH_LF})) begin
                r.lbl_vld  = (c != CH_NUL);
                r.lbl_part = PART_ETAG;
              end
            end
            default: begin
              // before start element, unused codes included
              r.st.pstate = ST_PRE;
              if (c == CH_LT) r.st.la = LA_OPEN;
            end
          endcase
        end
      end
    end
    return r;
  endfunction

  // Narrow the set of entities that still fit after byte c at position pos
  function automatic ent_out_t ent_step(logic [ENT_NUM-1:0] alive,
                                        logic [ENT_POS_W-1:0] pos, logic [7:0] c);
    ent_out_t r;
    r = '0;
    for (int e = 0; e < ENT_NUM; e++) begin
      r.alive[e] = alive[e] && (pos < ENT_LEN[e]) && (c == ENT_TEXT[e][pos]);
    end
    // lowest entity wins a full match
    for (int e = ENT_NUM - 1; e >= 0; e--) begin
      if (r.alive[e] && ((pos + ENT_POS_W'(1)) == ENT_LEN[e])) begin
        r.full = 1'b1;
        r.ch   = ENT_CHAR[e];
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/xled_front.sv =====
// Front part: entity decoder and element parser that turn one byte into a result bundle.
module xled_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  xled_pkg::in_item_t in_data_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output xled_pkg::bundle_t push_data_o
);
  import xled_pkg::*;

  logic [ENT_CNT_W-1:0] ent_cnt_q, ent_cnt_d, cnt_mid, cnt_fin;
  logic [ENT_NUM-1:0]   ent_alive_q, ent_alive_d;
  parse_st_t            st_q, st_d, st_mid, st_fin;
  logic                 bad_q, bad_d, bad_mid, bad_fin;
  logic                 stop_q, stop_d, stop_mid, stop_fin;

  logic [7:0]           c;
  logic                 le;
  logic                 accept;
  logic [ENT_POS_W-1:0] pos;
  ent_out_t             em;
  logic                 p1_go, p2_go;
  logic [7:0]           p1_char;
  parse_out_t           par1, par2;
  bundle_t              bundle;

  assign c      = in_data_i.character;
  assign le     = in_data_i.line_end;
  assign accept = in_valid_i && push_ready_i;
  assign pos    = ENT_POS_W'(ent_cnt_q - ENT_CNT_W'(1));
  assign em     = ent_step(ent_alive_q, pos, c);

  // Decode the raw byte
  always_comb begin
    cnt_mid     = ent_cnt_q;
    ent_alive_d = ent_alive_q;
    bad_mid     = bad_q;
    stop_mid    = stop_q;
    p1_go       = 1'b0;
    p1_char     = c;
    if (!stop_q && !bad_q) begin
      if (c == CH_NUL) begin
        // raw zero ends the content
        cnt_mid = '0;
        if (ent_cnt_q >= ENT_CNT_SHORT) begin
          bad_mid = 1'b1;
        end else begin
          stop_mid = 1'b1;
          p1_go    = 1'b1;
          p1_char  = CH_NUL;
        end
      end else if (ent_cnt_q == '0) begin
        if (c == CH_AMP) begin
          cnt_mid     = ENT_CNT_W'(1);
          ent_alive_d = '1;
        end else begin
          p1_go = 1'b1;
        end
      end else if (ent_cnt_q > ENT_CNT_MAX) begin
        cnt_mid = '0;
        bad_mid = 1'b1;
      end else begin
        cnt_mid     = ent_cnt_q + ENT_CNT_W'(1);
        ent_alive_d = em.alive;
        if (em.full) begin
          cnt_mid = '0;
          p1_go   = 1'b1;
          p1_char = em.ch;
        end else if (em.alive == '0 && pos != '0) begin
          cnt_mid = '0;
          bad_mid = 1'b1;
        end
      end
    end
  end

  assign par1   = parse_step(st_q, p1_char);
  assign st_mid = p1_go ? par1.st : st_q;

  // Content end at line end, unless already stopped or bad
  always_comb begin
    cnt_fin  = cnt_mid;
    bad_fin  = bad_mid;
    stop_fin = stop_mid;
    p2_go    = 1'b0;
    if (le && !stop_mid && !bad_mid) begin
      cnt_fin = '0;
      if (cnt_mid >= ENT_CNT_SHORT) begin
        bad_fin = 1'b1;
      end else begin
        stop_fin = 1'b1;
        p2_go    = 1'b1;
      end
    end
  end

  assign par2   = parse_step(st_mid, CH_NUL);
  assign st_fin = p2_go ? par2.st : st_mid;

  // Result bundle in emit order
  always_comb begin
    bundle = '0;
    bundle.vld[0]                 = p1_go && par1.lt_vld;
    bundle.item[0].character_res  = CH_LT;
    bundle.item[0].part           = PART_TEXT;
    bundle.vld[1]                 = p1_go && par1.lbl_vld;
    bundle.item[1].character_res  = p1_char;
    bundle.item[1].part           = par1.lbl_part;
    bundle.vld[2]                 = p2_go && par2.lt_vld;
    bundle.item[2].character_res  = CH_LT;
    bundle.item[2].part           = PART_TEXT;
    bundle.vld[3]                 = le && !(bundle.vld[0] && bundle.vld[1] && bundle.vld[2]);
    bundle.item[3].end_record     = 1'b1;
    bundle.item[3].last           = 1'b1;
    bundle.item[3].status         = bad_fin ? STAT_BAD_ENTITY :
                                    (st_fin.abort ? STAT_ABORT : STAT_OK);
  end

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && (bundle.vld != '0);
  assign push_data_o  = bundle;

  // Next line state; line end returns to reset
  always_comb begin
    ent_cnt_d = ent_cnt_q;
    st_d      = st_q;
    bad_d     = bad_q;
    stop_d    = stop_q;
    if (accept) begin
      if (le) begin
        ent_cnt_d = '0;
        st_d      = '{pstate: ST_PRE, la: LA_NONE, abort: 1'b0};
        bad_d     = 1'b0;
        stop_d    = 1'b0;
      end else begin
        ent_cnt_d = cnt_fin;
        st_d      = st_fin;
        bad_d     = bad_fin;
        stop_d    = stop_fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_cnt_q <= '0;
      st_q      <= '{pstate: ST_PRE, la: LA_NONE, abort: 1'b0};
      bad_q     <= 1'b0;
      stop_q    <= 1'b0;
    end else begin
      ent_cnt_q <= ent_cnt_d;
      st_q      <= st_d;
      bad_q     <= bad_d;
      stop_q    <= stop_d;
    end
  end

  // Entity match mask, meaningful only while an ampersand is pending
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_alive_q <= ent_alive_d;
    end
  end

endmodule

// ===== hdl/xled_queue.sv =====
// Short bundle queue that decouples the front part from the back part.
module xled_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  xled_pkg::bundle_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output xled_pkg::bundle_t pop_data_o
);
  import xled_pkg::*;

  localparam logic [QUEUE_AW-1:0] PTR_LAST = QUEUE_AW'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_AW:0]   CNT_FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  bundle_t             mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != CNT_FULL);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + QUEUE_AW'(1);
    if (pop)  rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + QUEUE_AW'(1);
    if (push && !pop) count_d = count_q + (QUEUE_AW + 1)'(1);
    else if (pop && !push) count_d = count_q - (QUEUE_AW + 1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/xled_back.sv =====
// Back part: drains result bundles one result per cycle into the output register while not stalled.
module xled_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  xled_pkg::bundle_t  pop_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output xled_pkg::out_item_t out_data_o
);
  import xled_pkg::*;

  logic [SLOTS-1:0]  done_q, done_d;
  logic [SLOTS-1:0]  pend, sel_oh, rest;
  logic [SLOT_W-1:0] sel_idx;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              take;

  // Lowest result of the head bundle not yet sent
  always_comb begin
    pend    = pop_valid_i ? (pop_data_i.vld & ~done_q) : '0;
    sel_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (pend[i]) sel_idx = SLOT_W'(i);
    end
    sel_oh = SLOTS'(1) << sel_idx;
    rest   = pend & ~sel_oh;
  end

  assign take        = (pend != '0) && (!out_valid_q || out_ready_i);
  assign pop_ready_o = take && (rest == '0);

  // Output register and per-bundle progress
  always_comb begin
    done_d      = done_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (take) begin
      out_valid_d = 1'b1;
      out_d       = pop_data_i.item[sel_idx];
      done_d      = (rest == '0) ? '0 : (done_q | sel_oh);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/xml_line_entity_decode_parser_unit.sv =====
// Top level of the XML line entity decode parser: front, bundle queue and back.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+----------------------------------
//   in       | input     | in_valid_i / in_ready_o | in_data_i  (character, line_end)
//   out      | output    | out_valid_o / out_ready_i | out_data_o (character_res, part,
//            |           |                         |   end_record, status, last)
//
// One byte is taken per cycle while in_ready_o is high; decode and parse of that byte finish
// in the cycle it is taken, and its results pass through the bundle queue and the back's
// output register to out_valid_o. Results leave that register at one per cycle while
// out_ready_i is high, so a byte with two or three results (such as the last byte of a line)
// holds the back until all have left; the four-entry bundle queue absorbs this before in_ready_o drops.
// Reset is asynchronous, active low, and needs no clearing pass.
module xml_line_entity_decode_parser_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  xled_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output xled_pkg::out_item_t out_data_o
);
  import xled_pkg::*;

  logic    push_valid, push_ready;
  bundle_t push_data;
  logic    pop_valid, pop_ready;
  bundle_t pop_data;

  // Decode and parse
  xled_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  // Decoupling queue
  xled_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  // Result serializer
  xled_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hdl/xled_checker.sv =====
// Port-level checks of the XML line entity decode parser, bound to its top level.
module xled_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input xled_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input xled_pkg::out_item_t out_data_o
);
  import xled_pkg::*;

  // A stalled result transfer holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // End record carries only a known status and closes the line
  a_end_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_record |->
      out_data_o.last && out_data_o.character_res == CH_NUL &&
      out_data_o.part == PART_TAG &&
      (out_data_o.status == STAT_OK || out_data_o.status == STAT_ABORT ||
       out_data_o.status == STAT_BAD_ENTITY))
    else $error("malformed end record");

  // Labelled results carry a nonzero byte and a valid label, never line status
  a_label_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.end_record |->
      !out_data_o.last && out_data_o.status == STAT_OK &&
      out_data_o.character_res != CH_NUL &&
      (out_data_o.part == PART_TAG || out_data_o.part == PART_ANAM ||
       out_data_o.part == PART_AVAL || out_data_o.part == PART_TEXT ||
       out_data_o.part == PART_ETAG))
    else $error("malformed labelled result");

endmodule

bind xml_line_entity_decode_parser_unit xled_checker u_xled_checker (.*);

// ===== tb/sv/xml_line_entity_decode_parser_unit_test.sv =====
// Testbench of the XML line entity decode parser: directed and random lines checked by a predictor.
module xml_line_entity_decode_parser_unit_test;
  import xled_pkg::*;

  localparam int         IDLE_LIMIT   = 2000;
  localparam int         BYTES_TARGET = 470;
  localparam int         ENT_KINDS    = 5;
  localparam logic [7:0] CH_APOS      = 8'h27;

  typedef enum int {FIT_NONE, FIT_PREFIX, FIT_FULL} ent_fit_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  xml_line_entity_decode_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Predictor state: one line in flight
  logic [7:0] ent_bytes [ENT_KINDS];
  int         ent_held;      // 0 no '&' pending, else 1 + bytes held
  logic [2:0] pstate;
  logic [1:0] lookahead;
  logic       aborted;
  logic       bad_entity;
  logic       content_done;
  int         step_results;

  string      ent_names [ENT_KINDS] = '{"lt;", "gt;", "amp;", "apos;", "quot;"};
  logic [7:0] ent_chars [ENT_KINDS] = '{CH_LT, CH_GT, CH_AMP, CH_APOS, CH_DQUOTE};

  out_item_t  expected_results [$];
  logic [7:0] line_bytes [$];

  // Run bookkeeping
  int   errors;
  int   bytes_sent;
  int   lines_sent;
  int   results_seen;
  int   status_seen [3];
  int   idle_cycles;
  logic steady;   // no gaps on either side while set

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Random gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic void put_result(logic [7:0] ch, logic [2:0] pt, logic er,
                                     logic [1:0] st, logic lst);
    out_item_t r;
    if (step_results >= 3) return;
    r = '{character_res: ch, part: pt, end_record: er, status: st, last: lst};
    expected_results = {expected_results, r};
    step_results++;
  endfunction

  function automatic void label_byte(logic [7:0] c, logic [2:0] pt);
    if (c != CH_NUL) put_result(c, pt, 1'b0, STAT_OK, 1'b0);
  endfunction

  function automatic void clear_line();
    ent_held     = 0;
    pstate       = ST_PRE;
    lookahead    = LA_NONE;
    aborted      = 1'b0;
    bad_entity   = 1'b0;
    content_done = 1'b0;
  endfunction

  // Element parser on one decoded byte
  function automatic void parse_decoded(logic [7:0] c);
    logic [7:0] want;
    if (aborted || bad_entity) return;
    // '=' or closing quote waits for its partner byte
    if (lookahead == LA_EQUAL || lookahead == LA_QUOTE) begin
      want = (lookahead == LA_EQUAL) ? CH_DQUOTE : CH_GT;
      if (c == want) pstate = (lookahead == LA_EQUAL) ? ST_AVAL : ST_TEXT;
      else aborted = 1'b1;
      lookahead = LA_NONE;
      return;
    end
    // held '<': end tag, text '<', or start tag
    if (lookahead == LA_OPEN) begin
      lookahead = LA_NONE;
      if (c == CH_SLASH) begin
        pstate = ST_END;
        return;
      end
      if (pstate == ST_TEXT) label_byte(CH_LT, PART_TEXT);
      else pstate = ST_START;
    end
    case (pstate)
      ST_START: begin
        if (c == CH_SPACE) pstate = ST_ATTR;
        else if (c == CH_GT) pstate = ST_TEXT;
        else label_byte(c, PART_TAG);
      end
      ST_ATTR: begin
        if (c == CH_EQUAL) lookahead = LA_EQUAL;
        else if (c == CH_GT) pstate = ST_TEXT;
        else label_byte(c, PART_ANAM);
      end
      ST_AVAL: begin
        if (c == CH_DQUOTE) lookahead = LA_QUOTE;
        else label_byte(c, PART_AVAL);
      end
      ST_TEXT: begin
        if (c == CH_LT) lookahead = LA_OPEN;
        else label_byte(c, PART_TEXT);
      end
      ST_END: begin
        if (c != CH_GT && c != CH_CR && c != CH_LF) label_byte(c, PART_ETAG);
      end
      default: begin
        pstate = ST_PRE;
        if (c == CH_LT) lookahead = LA_OPEN;
      end
    endcase
  endfunction

  // How the k bytes held after '&' compare with the predefined entities
  function automatic ent_fit_e entity_fit(int k, output logic [7:0] ch);
    ent_fit_e best;
    bit       ok;
    best = FIT_NONE;
    ch   = CH_NUL;
    for (int e = 0; e < ENT_KINDS; e++) begin
      ok = (k <= ent_names[e].len());
      for (int i = 0; ok && i < k && i < ENT_KINDS; i++)
        if (ent_bytes[i] != ent_names[e][i]) ok = 1'b0;
      if (ok) begin
        if (k == ent_names[e].len()) begin
          ch = ent_chars[e];
          return FIT_FULL;
        end
        best = FIT_PREFIX;
      end
    end
    return best;
  endfunction

  // Content ends: short tail after '&' is dropped, a longer one is bad
  function automatic void end_of_content();
    int k;
    if (ent_held > 0) begin
      k        = ent_held - 1;
      ent_held = 0;
      if (k >= 2) begin
        bad_entity = 1'b1;
        return;
      end
    end
    content_done = 1'b1;
    parse_decoded(CH_NUL);
  endfunction

  // One raw byte in, its results onto expected_results
  function automatic void predict_byte(logic [7:0] c, logic le);
    logic [7:0] ch;
    ent_fit_e   fit;
    logic [1:0] st;
    step_results = 0;
    if (!content_done && !bad_entity) begin
      if (c == CH_NUL) begin
        end_of_content();
      end else if (ent_held == 0) begin
        if (c == CH_AMP) ent_held = 1;
        else parse_decoded(c);
      end else if (ent_held > ENT_KINDS) begin
        ent_held   = 0;
        bad_entity = 1'b1;
      end else begin
        ent_bytes[ent_held-1] = c;
        ent_held++;
        fit = entity_fit(ent_held - 1, ch);
        if (fit == FIT_FULL) begin
          ent_held = 0;
          parse_decoded(ch);
        end else if (fit == FIT_NONE && ent_held - 1 >= 2) begin
          ent_held   = 0;
          bad_entity = 1'b1;
        end
      end
    end
    if (le) begin
      if (!content_done && !bad_entity) end_of_content();
      st = bad_entity ? STAT_BAD_ENTITY : (aborted ? STAT_ABORT : STAT_OK);
      put_result(CH_NUL, PART_TAG, 1'b1, st, 1'b1);
      clear_line();
    end
  endfunction

  // ---------------------------------------------------------------- driving

  // One input transfer; the byte is predicted at the edge that takes it
  task automatic send_byte(logic [7:0] c, logic le);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{character: c, line_end: le};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_byte(c, le);
    bytes_sent++;
  endtask

  // Append one byte to the line being built
  function automatic void append_byte(logic [7:0] b);
    line_bytes = {line_bytes, b};
  endfunction

  task automatic send_line();
    if (line_bytes.size() == 0) append_byte(CH_LF);
    for (int i = 0; i < line_bytes.size(); i++)
      send_byte(line_bytes[i], i == line_bytes.size() - 1);
    lines_sent++;
    line_bytes = {};
  endtask

  // Sender holds off until every expected result has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  task automatic send_text(string s);
    add_text(s);
    send_line();
  endtask

  // Content byte that keeps a line well formed
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CH_LT || b == CH_GT || b == CH_AMP || b == CH_DQUOTE ||
           b == CH_EQUAL || b == CH_SPACE || b == CH_SLASH);
    return b;
  endfunction

  // Byte biased toward the ones the decoder and parser react to
  function automatic logic [7:0] noisy_byte();
    logic [7:0] marks [4] = '{CH_DQUOTE, CH_EQUAL, CH_GT, CH_SLASH};
    int         r;
    r = $urandom_range(0, 9);
    if (r <= 5) return 8'($urandom_range(0, 255));
    if (r == 6) return CH_AMP;
    if (r == 7) return CH_LT;
    if (r == 8) return marks[$urandom_range(0, 3)];
    return CH_NUL;
  endfunction

  function automatic void add_field(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        append_byte(CH_AMP);
        add_text(ent_names[$urandom_range(0, ENT_KINDS - 1)]);
      end else begin
        append_byte(plain_byte());
      end
    end
  endfunction

  // <tag [name="value"]>text</tag> with random content
  function automatic void build_clean_line();
    line_bytes = {};
    append_byte(CH_LT);
    add_field($urandom_range(1, 4));
    if ($urandom_range(0, 2) != 0) begin
      append_byte(CH_SPACE);
      add_field($urandom_range(1, 4));
      append_byte(CH_EQUAL);
      append_byte(CH_DQUOTE);
      add_field($urandom_range(0, 5));
      append_byte(CH_DQUOTE);
    end
    append_byte(CH_GT);
    add_field($urandom_range(0, 6));
    // a lone '<' inside text
    if ($urandom_range(0, 4) == 0) begin
      append_byte(CH_LT);
      add_field($urandom_range(1, 3));
    end
    append_byte(CH_LT);
    append_byte(CH_SLASH);
    add_field($urandom_range(1, 4));
    append_byte(CH_GT);
    if ($urandom_range(0, 3) == 0) begin
      append_byte(CH_CR);
      append_byte(CH_LF);
    end
  endfunction

  // Garbage, a clean line with one byte hit, a cut line, or a stray entity
  function automatic void build_noise_line();
    string alphabet;
    int    pick;
    int    pos;
    alphabet = "aglmopqstu;";
    pick     = $urandom_range(0, 3);
    if (pick == 0) begin
      line_bytes = {};
      repeat ($urandom_range(1, 12)) append_byte(noisy_byte());
    end else begin
      build_clean_line();
      pos = $urandom_range(0, line_bytes.size() - 1);
      if (pick == 1) begin
        line_bytes[pos] = noisy_byte();
      end else if (pick == 2) begin
        while (line_bytes.size() > pos + 1) void'(line_bytes.pop_back());
      end else begin
        repeat ($urandom_range(1, 5))
          line_bytes.insert(pos, alphabet[$urandom_range(0, alphabet.len() - 1)]);
        line_bytes.insert(pos, CH_AMP);
      end
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    errors++;
    $display("ERROR result %0d %s: got %0h, expected %0h", results_seen, what, got, want);
  endtask

  // Receiver: ready with random stalls
  initial begin
    out_ready_i <= 1'b1;
    forever begin
      int stall;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Each output transfer against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (out_data_o.end_record && out_data_o.status <= STAT_BAD_ENTITY)
        status_seen[out_data_o.status]++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_data_o.character_res, CH_NUL);
      end else begin
        want_item = expected_results.pop_front();
        if (out_data_o.character_res !== want_item.character_res)
          report_mismatch("character_res", out_data_o.character_res, want_item.character_res);
        if (out_data_o.part !== want_item.part)
          report_mismatch("part", 8'(out_data_o.part), 8'(want_item.part));
        if (out_data_o.end_record !== want_item.end_record)
          report_mismatch("end_record", 8'(out_data_o.end_record), 8'(want_item.end_record));
        if (out_data_o.status !== want_item.status)
          report_mismatch("status", 8'(out_data_o.status), 8'(want_item.status));
        if (out_data_o.last !== want_item.last)
          report_mismatch("last", 8'(out_data_o.last), 8'(want_item.last));
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, expected_results.size());
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // Every predefined entity in attribute names, attribute values and text, and a 0xFF byte
  task automatic test_entities();
    send_text("<p &apos;=\"&quot;\">&lt;</p");
    add_text("<>&gt;<&amp;");
    append_byte(8'hFF);
    send_line();
    wait_drained();
  endtask

  // Parser transitions: extra attributes, direct end tag, held '<'
  task automatic test_parser_states();
    add_text("<a b c=\"v w\">t</a>");
    append_byte(CH_CR);
    append_byte(CH_LF);
    send_line();
    send_text("</x>");
    send_text("<a b>c<");
    add_text("<a>");
    append_byte(8'h80);
    append_byte(8'h7F);
    send_line();
    wait_drained();
  endtask

  // Short and bad entity tails, raw zero, malformed quotes, status priority
  task automatic test_line_special_cases();
    send_text("<x>y&l");
    send_text("<x>&");
    send_text("<x>&zq");
    send_text("<x>&quo");
    send_text("&aposx");
    add_text("<a");
    append_byte(CH_NUL);
    add_text("&zz");
    send_line();
    append_byte(CH_NUL);
    send_line();
    send_text("<a b=");
    send_text("<a b=\"v\"x>");
    send_text("<a b=x&qq;");
    wait_drained();
  endtask

  // Clean lines back to back with no gaps, then a full drain pause
  task automatic test_drain_pause();
    steady = 1'b1;
    repeat (3) begin
      build_clean_line();
      send_line();
    end
    steady = 1'b0;
    wait_drained();
    build_clean_line();
    send_line();
    wait_drained();
  endtask

  // Mostly well-formed lines with random content, the rest noise
  task automatic test_random_lines();
    while (bytes_sent < BYTES_TARGET) begin
      steady = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 3) != 0) build_clean_line();
      else build_noise_line();
      send_line();
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    steady       = 1'b0;
    errors       = 0;
    bytes_sent   = 0;
    lines_sent   = 0;
    results_seen = 0;
    status_seen  = '{0, 0, 0};
    step_results = 0;
    foreach (ent_bytes[i]) ent_bytes[i] = CH_NUL;
    clear_line();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_entities();
    test_parser_states();
    test_line_special_cases();
    test_drain_pause();
    test_random_lines();

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d bytes in %0d lines, %0d results checked", bytes_sent, lines_sent,
             results_seen);
    $display("Line status: %0d ok, %0d malformed, %0d bad entity", status_seen[STAT_OK],
             status_seen[STAT_ABORT], status_seen[STAT_BAD_ENTITY]);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/xled_pkg.sv
hdl/xled_front.sv
hdl/xled_queue.sv
hdl/xled_back.sv
hdl/xml_line_entity_decode_parser_unit.sv
hdl/xled_checker.sv
tb/sv/xml_line_entity_decode_parser_unit_test.sv
